>>> design/bpa_pkg.sv
// package with types and constants of the buddy page allocator
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int unsigned MODE_W   = 2;
    localparam int unsigned ORDER_W  = 4;
    localparam int unsigned PAGE_W   = 12;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_W    = 13;

    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_INIT    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_BLOCK = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FREE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD      = 2'd3;

    localparam logic [CFG_W-1:0] MANAGED_RESET = 13'd4096;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [ORDER_W-1:0] order;
        logic [PAGE_W-1:0]  page_number;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   result_page;
    } t_rsp;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_SPLIT,
        S_FREE_CHK,
        S_MERGE,
        S_RES_RD,
        S_RES_CHK,
        S_RES_SPLIT,
        S_INIT,
        S_DONE
    } t_state;

endpackage

>>> design/bpa_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps

module bpa_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/buddy_page_allocator.sv
// buddy page allocator top level: fsm around one free-bit memory
`timescale 1ns / 1ps
//
// channel | direction | signals                          | payload
// --------+-----------+----------------------------------+---------------------------
// request | in        | i_in_valid, o_in_stall, i_in_data | mode, order, page_number
// result  | out       | o_out_valid, i_out_stall, o_out_data | status, result_page
// config  | in        | i_cfg_we, i_cfg_wdata            | managed_pages
//
// one request at a time; every step is one memory access of the free-bit ram
// allocate scans free bits one at a time, a read state and a check state per bit;
// free walks up and reserve walks down the orders, one order at a time
// after reset a clearing pass zeroes all 2*NUM_PAGES ram entries, no request taken
// the result sits in an output register; a stalled result holds the request side

module buddy_page_allocator
    import bpa_pkg::*;
#(
    parameter int unsigned TOP_ORDER = 10,
    parameter int unsigned NUM_PAGES = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  t_req         i_in_data,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output t_rsp         o_out_data,
    input  logic         i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int unsigned MAP_SIZE = 2 * NUM_PAGES;
    localparam int unsigned AW = $clog2(MAP_SIZE);
    localparam int unsigned IW = $clog2(NUM_PAGES) + 1;   // block index with room
    localparam int unsigned KW = $clog2(TOP_ORDER + 2);   // order counter

    t_state r_state, n_state;
    logic [CFG_W-1:0] r_managed;
    t_req  r_req;
    logic [KW-1:0] r_k, n_k;                  // current order
    logic [IW-1:0] r_idx, n_idx;              // current block index
    logic [AW:0]   r_clr, n_clr;              // clearing pass / init counter / merge phase
    t_rsp  r_rsp, n_rsp;
    logic  r_out_valid, n_out_valid;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic          ram_wdata;
    logic          ram_rdata;

    // base address of an order in the map: 2*N - 2*N>>k
    function automatic logic [AW:0] base_of(input logic [KW-1:0] k);
        logic [AW:0] full;
        full = (AW+1)'(MAP_SIZE);
        return full - (full >> k);
    endfunction

    function automatic logic [IW-1:0] blocks_of(input logic [KW-1:0] k);
        return IW'(NUM_PAGES >> k);
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [KW-1:0] k,
                                              input logic [IW-1:0] i);
        logic [AW:0] s;
        s = base_of(k) + (AW+1)'(i);
        return s[AW-1:0];
    endfunction

    bpa_ram #(.WIDTH(1), .DEPTH(MAP_SIZE)) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    // request decode helpers
    logic [KW-1:0] req_k;
    logic          order_bad;
    logic [PAGE_W-1:0] align_mask;
    logic [IW-1:0] free_idx;
    logic [IW-1:0] init_cnt;
    logic [CFG_W-1:0] limit;
    logic [IW-1:0] res_idx;    // page >> r_k
    logic [IW-1:0] buddy;
    logic          buddy_ok;

    always_comb begin
        order_bad  = (32'(r_req.order) > TOP_ORDER);
        req_k      = order_bad ? KW'(0) : KW'(r_req.order);
        align_mask = PAGE_W'((32'd1 << r_req.order) - 32'd1);
        free_idx   = IW'(32'(r_req.page_number) >> r_req.order);
        limit      = (32'(r_managed) > NUM_PAGES) ? CFG_W'(NUM_PAGES) : r_managed;
        init_cnt   = IW'(32'(limit) >> TOP_ORDER);
        res_idx    = IW'(32'(r_req.page_number) >> r_k);
        buddy      = r_idx ^ IW'(1);
        buddy_ok   = (buddy < blocks_of(r_k));
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_managed   <= MANAGED_RESET;
            r_out_valid <= 1'b0;
            r_clr       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_clr       <= n_clr;
            if (i_cfg_we) begin
                r_managed <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_idx <= n_idx;
        r_rsp <= n_rsp;
        if (r_state == S_IDLE && i_in_valid) begin
            r_req <= i_in_data;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:     if (r_clr == (AW+1)'(MAP_SIZE - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_data.mode)
                        MODE_ALLOC:   n_state = S_ALLOC_RD;
                        MODE_FREE:    n_state = S_FREE_CHK;
                        MODE_RESERVE: n_state = S_RES_RD;
                        MODE_INIT:    n_state = S_INIT;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_ALLOC_RD: begin
                if (order_bad || 32'(r_k) > TOP_ORDER) n_state = S_DONE;
                else if (r_idx >= blocks_of(r_k)) n_state = S_ALLOC_RD;
                else n_state = S_ALLOC_CHK;
            end
            S_ALLOC_CHK: n_state = ram_rdata ? S_SPLIT : S_ALLOC_RD;
            S_SPLIT:     if (r_k == req_k) n_state = S_DONE;
            S_FREE_CHK: begin
                if (order_bad || (r_req.page_number & align_mask) != '0
                    || free_idx >= blocks_of(KW'(r_req.order))) n_state = S_DONE;
                else n_state = S_MERGE;
            end
            S_MERGE: begin
                // phase by r_clr: 0 read buddy, 1 check and clear buddy, 2 clear self
                if (r_clr[1:0] == 2'd0) begin
                    if (32'(r_k) >= TOP_ORDER || !buddy_ok) n_state = S_DONE;
                end else if (r_clr[1:0] == 2'd1) begin
                    if (!ram_rdata) n_state = S_DONE;
                end
            end
            S_RES_RD: begin
                if (32'(r_req.page_number) >= NUM_PAGES) n_state = S_DONE;
                else n_state = S_RES_CHK;
            end
            S_RES_CHK: begin
                if (ram_rdata) n_state = (r_k == '0) ? S_DONE : S_RES_SPLIT;
                else n_state = (r_k == '0) ? S_DONE : S_RES_RD;
            end
            S_RES_SPLIT: if (r_k == KW'(1)) n_state = S_DONE;
            S_INIT:      if (r_clr[IW-1:0] >= init_cnt) n_state = S_DONE;
            S_DONE:      if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_k         = r_k;
        n_idx       = r_idx;
        n_clr       = r_clr;
        n_rsp       = r_rsp;
        n_out_valid = r_out_valid && i_out_stall;
        ram_we      = 1'b0;
        ram_addr    = addr_of(r_k, r_idx);
        ram_wdata   = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_clr[AW-1:0];
                n_clr    = r_clr + 1'b1;
            end
            S_IDLE: begin
                n_clr = '0;
                n_rsp = '{status: ST_OK, result_page: '0};
                n_idx = '0;
                n_k   = (i_in_data.mode == MODE_RESERVE) ? KW'(TOP_ORDER)
                                                         : KW'(i_in_data.order);
            end
            S_ALLOC_RD: begin
                if (order_bad) begin
                    n_rsp.status = ST_BAD;
                end else if (32'(r_k) > TOP_ORDER) begin
                    n_rsp.status = ST_NO_BLOCK;
                end else if (r_idx >= blocks_of(r_k)) begin
                    n_k   = r_k + 1'b1;
                    n_idx = '0;
                end
            end
            S_ALLOC_CHK: begin
                if (ram_rdata) begin
                    ram_we = 1'b1;   // take the block
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SPLIT: begin
                if (r_k == req_k) begin
                    n_rsp.result_page = PAGE_W'(32'(r_idx) << r_k);
                end else begin
                    // right half of the next order down stays free
                    ram_we    = 1'b1;
                    ram_wdata = 1'b1;
                    ram_addr  = addr_of(r_k - 1'b1, {r_idx[IW-2:0], 1'b1});
                    n_k       = r_k - 1'b1;
                    n_idx     = {r_idx[IW-2:0], 1'b0};
                end
            end
            S_FREE_CHK: begin
                if (order_bad || (r_req.page_number & align_mask) != '0
                    || free_idx >= blocks_of(KW'(r_req.order))) begin
                    n_rsp.status = ST_BAD;
                end
                n_idx = free_idx;
                n_clr = '0;
            end
            S_MERGE: begin
                if (r_clr[1:0] == 2'd0) begin
                    if (32'(r_k) >= TOP_ORDER || !buddy_ok) begin
                        // no merge possible, the block ends up free here
                        ram_we    = 1'b1;
                        ram_wdata = 1'b1;
                    end else begin
                        ram_addr = addr_of(r_k, buddy);
                        n_clr    = r_clr + 1'b1;
                    end
                end else if (r_clr[1:0] == 2'd1) begin
                    if (ram_rdata) begin
                        ram_we   = 1'b1;   // clear buddy
                        ram_addr = addr_of(r_k, buddy);
                        n_clr    = r_clr + 1'b1;
                    end else begin
                        ram_we    = 1'b1;  // buddy busy, mark self free
                        ram_wdata = 1'b1;
                    end
                end else begin
                    // clear self and climb to the parent
                    ram_we = 1'b1;
                    n_k    = r_k + 1'b1;
                    n_idx  = r_idx >> 1;
                    n_clr  = '0;
                end
            end
            S_RES_RD: begin
                if (32'(r_req.page_number) >= NUM_PAGES) begin
                    n_rsp.status = ST_BAD;
                end
                ram_addr = addr_of(r_k, res_idx);
                n_idx    = res_idx;
            end
            S_RES_CHK: begin
                ram_addr = addr_of(r_k, r_idx);
                if (ram_rdata) begin
                    ram_we = 1'b1;
                    n_rsp.result_page = r_req.page_number;
                end else if (r_k == '0) begin
                    n_rsp.status = ST_NOT_FREE;
                end else begin
                    n_k = r_k - 1'b1;
                end
            end
            S_RES_SPLIT: begin
                ram_we    = 1'b1;
                ram_wdata = 1'b1;
                ram_addr  = addr_of(r_k - 1'b1,
                                    IW'(32'(r_req.page_number) >> (r_k - 1'b1)) ^ IW'(1));
                n_k       = r_k - 1'b1;
            end
            S_INIT: begin
                if (r_clr[IW-1:0] < init_cnt) begin
                    ram_we    = 1'b1;
                    ram_wdata = 1'b1;
                    ram_addr  = addr_of(KW'(TOP_ORDER), r_clr[IW-1:0]);
                    n_clr     = r_clr + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                end
                if (r_rsp.status != ST_OK) begin
                    n_rsp.result_page = '0;
                end
            end
            default: ;
        endcase
    end

    // output register holds a result while the request side takes the next one
    t_rsp r_out;
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
            r_out <= (r_rsp.status != ST_OK) ? '{status: r_rsp.status, result_page: '0}
                                             : r_rsp;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
